### hdl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg - shared types and constants for the serial register access master
// Frame geometry, register length table and the request/response records.
// ----------------------------------------------------------------------------
package srm_pkg;

   localparam int NUM_CHIPS   = 8;
   localparam int REG_COUNT   = 13;
   localparam int TABLE_SIZE  = 13;
   localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

   localparam logic [6:0] HEADER      = 7'd8;
   localparam logic [6:0] TRAILER     = 7'd4;
   localparam logic [6:0] READ_EXTRA  = 7'd2;
   localparam logic [6:0] DEFAULT_LEN = 7'd16;

   // request kind carried on tuser
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_ADDR = 1'b1;

   localparam logic [6:0] LEN_TABLE [TABLE_SIZE] = '{
      7'd64, 7'd32, 7'd32, 7'd32, 7'd32, 7'd16, 7'd64,
      7'd64, 7'd32, 7'd32, 7'd32, 7'd32, 7'd16
   };

   typedef struct packed {
      logic        func;
      logic        is_read;
      logic [2:0]  chip;
      logic [6:0]  reg_addr;
      logic [63:0] write_data;
      logic        miso;
   } req_item_type;

   typedef struct packed {
      logic        mosi;
      logic [7:0]  cs_mask;
      logic        busy_res;
      logic        done_res;
      logic        status;
      logic [63:0] read_data;
   } rsp_item_type;

   // length of an accepted register address
   function automatic logic [6:0] reg_len(input logic [6:0] addr);
      logic [6:0] len;
      len = DEFAULT_LEN;
      if (8'(addr) < 8'(TABLE_SIZE)) begin
         len = LEN_TABLE[TABLE_IDX_W'(addr)];
      end
      return len;
   endfunction

endpackage

### hdl/srm_engine.sv
// ----------------------------------------------------------------------------
// srm_engine - frame sequencer
// Holds the frame state and works out one response per request in one pass.
// ----------------------------------------------------------------------------
module srm_engine import srm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result,
   output logic [6:0]   period_now
);

   logic [6:0]  period_ff, period_in;
   logic        active_ff, active_in;
   logic        read_ff, read_in;
   logic [2:0]  chip_ff, chip_in;
   logic [6:0]  len_ff, len_in;
   logic [63:0] tx_ff, tx_in;
   logic [63:0] rx_ff, rx_in;
   logic [6:0]  addr_ff, addr_in;

   logic [6:0] cs_end, cs_stop, total, data_idx;
   logic [5:0] rx_pos, tx_pos;

   assign period_now = period_ff;

   always_comb begin
      period_in = period_ff;
      active_in = active_ff;
      read_in   = read_ff;
      chip_in   = chip_ff;
      len_in    = len_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      addr_in   = addr_ff;
      result    = '0;

      cs_end   = len_ff + (read_ff ? READ_EXTRA : 7'd0);
      cs_stop  = HEADER + cs_end;
      total    = cs_stop + TRAILER;
      data_idx = period_ff - HEADER;
      rx_pos   = 6'(data_idx - 7'd1) ^ 6'd15;   // word-wise MSB first
      tx_pos   = 6'(data_idx) ^ 6'd15;

      if (item.func == FUNC_START) begin
         if (active_ff) begin
            result.busy_res = 1'b1;
         end else if (8'(item.reg_addr) >= 8'(REG_COUNT)) begin
            result.status = STATUS_BAD_ADDR;
         end else begin
            read_in   = item.is_read;
            chip_in   = item.chip;
            addr_in   = item.reg_addr;
            len_in    = reg_len(item.reg_addr);
            tx_in     = item.is_read ? 64'd0 : item.write_data;
            rx_in     = '0;
            period_in = '0;
            active_in = 1'b1;
            result.busy_res = 1'b1;
         end
      end else if (active_ff) begin
         if (period_ff == 7'd0) begin
            result.mosi = read_ff;
         end else if (period_ff < HEADER) begin
            result.mosi = addr_ff[3'(HEADER - 7'd1 - period_ff)];
         end else if (read_ff) begin
            result.mosi = addr_ff[0];
            if (data_idx >= 7'd1 && data_idx <= len_ff && item.miso) begin
               rx_in[rx_pos] = 1'b1;
            end
         end else if (data_idx < len_ff) begin
            result.mosi = tx_ff[tx_pos];
         end

         if (period_ff < cs_stop && 4'({1'b0, chip_ff}) < 4'(NUM_CHIPS)) begin
            result.cs_mask = 8'd1 << chip_ff;
         end

         result.busy_res = 1'b1;
         if (period_ff + 7'd1 >= total) begin
            active_in        = 1'b0;
            period_in        = '0;
            result.done_res  = 1'b1;
            result.read_data = read_ff ? rx_in : 64'd0;
         end else begin
            period_in = period_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         active_ff <= 1'b0;
         read_ff   <= 1'b0;
         chip_ff   <= '0;
         len_ff    <= '0;
         tx_ff     <= '0;
         rx_ff     <= '0;
         addr_ff   <= '0;
      end else if (fire) begin
         period_ff <= period_in;
         active_ff <= active_in;
         read_ff   <= read_in;
         chip_ff   <= chip_in;
         len_ff    <= len_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         addr_ff   <= addr_in;
      end
   end

endmodule

### hdl/serial_register_access_master.sv
// ----------------------------------------------------------------------------
// serial_register_access_master - register read/write master for serial chips
// Each request is a start or one serial clock period; each gives one response.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_tvalid/tready    | tuser = kind, tdata = fields
//  rsp_    | out       | rsp_tvalid/tready    | tdata = serial outputs, status
//
//  A request is captured in the input register, evaluated in one pass by the
//  frame sequencer and lands in the response register; one request per cycle
//  is sustained while the response is not stalled, set by the single pass
//  through the sequencer's count and shift logic.
//  Synchronous active-high reset empties both registers and closes any frame.
//  A stalled response holds the pipe; the input register still takes a new
//  request whenever the pipe advances in the same cycle.
// ----------------------------------------------------------------------------
module serial_register_access_master import srm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // bit 0 is_read, 3:1 chip, 10:4 reg_addr, 74:11 write_data, 75 miso,
   // 79:76 zero
   input  logic [79:0] req_tdata,
   // bit 0 func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bit 0 mosi, 8:1 cs_mask, 9 busy_res, 10 done_res, 11 status,
   // 75:12 read_data, 79:76 zero
   output logic [79:0] rsp_tdata
);

   req_item_type in_ff, in_in;
   logic         in_valid_ff;
   rsp_item_type out_ff, result;
   logic         out_valid_ff;
   logic         advance;
   logic [6:0]   period_now;

   // pipe moves when the response slot is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_in.func       = req_tuser;
   assign in_in.is_read    = req_tdata[0];
   assign in_in.chip       = req_tdata[3:1];
   assign in_in.reg_addr   = req_tdata[10:4];
   assign in_in.write_data = req_tdata[74:11];
   assign in_in.miso       = req_tdata[75];

   srm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_ff),
      .result     (result),
      .period_now (period_now)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.read_data, out_ff.status, out_ff.done_res,
                        out_ff.busy_res, out_ff.cs_mask, out_ff.mosi};

   // at most one chip selected per period
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0(out_ff.cs_mask))
      else $error("more than one chip select active");

   // a rejected start never reports an open frame
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == STATUS_BAD_ADDR) |-> !out_ff.busy_res)
      else $error("bad address reported with busy");

   // the end of a frame is always inside a frame
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.done_res) |-> out_ff.busy_res)
      else $error("done without busy");

   // the period counter never runs past the longest frame
   assert property (@(posedge clock) disable iff (reset)
      period_now < 7'd64 + READ_EXTRA + HEADER + TRAILER)
      else $error("period counter out of range");

   // a stalled response is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> $stable(out_ff))
      else $error("stalled response changed");

endmodule
